### rtl/lkc_pkg.sv
`timescale 1ns / 1ps

package lkc_pkg;

    // Field widths of one request and one response beat.
    localparam int CODE_W   = 21;
    localparam int FSIZE_W  = 16;
    localparam int HANDLE_W = 32;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 7;

    localparam int DEFAULT_MAX_ENTRIES = 64;

    localparam logic [CAP_W-1:0]   CAPACITY_RESET = CAP_W'(64);
    localparam logic [STAMP_W-1:0] STAMP_NEWEST   = 32'hffff_ffff;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PARAM = 2'd2;

    // One stored cache entry as it sits in the entry memory.
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [FSIZE_W-1:0]  font_size;
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

### rtl/lkc_if.sv
`timescale 1ns / 1ps

// Request channel: one beat carries one add or lookup command.
interface lkc_req_if
    import lkc_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [CODE_W-1:0]   char_code;
    logic [FSIZE_W-1:0]  font_size;
    logic [HANDLE_W-1:0] payload_handle;
    logic [STAMP_W-1:0]  now_ms;

    modport source (
        output valid, command, char_code, font_size, payload_handle, now_ms,
        input  ready
    );
    modport sink (
        input  valid, command, char_code, font_size, payload_handle, now_ms,
        output ready
    );
endinterface

// Response channel: one beat per accepted request.
interface lkc_rsp_if
    import lkc_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;

    modport source (
        output valid, status, found_handle, evicted, evicted_handle,
        input  ready
    );
    modport sink (
        input  valid, status, found_handle, evicted, evicted_handle,
        output ready
    );
endinterface

### rtl/lru_keyed_cache.sv
`timescale 1ns / 1ps

// Fully associative glyph cache keyed by character code and font size, with
// least-recently-used replacement. All entries live in one synchronous RAM and
// are visited one per cycle by a scan sequencer, so the cost of a request is
// set by that single read port. An add that finds a free slot, an add that
// carries a null handle and a lookup on an empty cache go straight to the
// finishing step. A lookup scans until it hits an entry or has read every
// filled entry; an add into a full cache reads every filled entry to find the
// oldest stamp. Each scan read passes the registered RAM read port before it
// is compared, and the finishing step then writes the response register. One
// request is processed at a time; the response register lets the next request
// be accepted while the previous response is still waiting, and a request that
// reaches its finishing step before that response is taken waits there. The
// capacity register may only be written while the cache is idle; zero acts as
// one and values above MAX_ENTRIES act as MAX_ENTRIES. Entry contents are not
// cleared at reset: only entries below the fill count are ever read.
module lru_keyed_cache
    import lkc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    lkc_req_if.sink          req,
    lkc_rsp_if.source        rsp
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    state_t state_reg, state_next;

    logic [CAP_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    fill_reg, fill_next;

    // The request being worked on.
    logic                cmd_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [FSIZE_W-1:0]  fsize_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [STAMP_W-1:0]  now_reg;

    // Outcome flags that steer the finishing step.
    logic                bad_reg, bad_next;
    logic                append_reg, append_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;

    // Scan pipeline: issue counter and the index of the beat now out of RAM.
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                cmp_valid_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;

    // Running oldest entry during an eviction scan, and the lookup hit.
    logic [STAMP_W-1:0]  best_stamp_reg, best_stamp_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [HANDLE_W-1:0] best_handle_reg, best_handle_next;
    logic [HANDLE_W-1:0] found_reg, found_next;

    // Response register.
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [HANDLE_W-1:0] out_found_reg, out_found_next;
    logic                out_evicted_reg, out_evicted_next;
    logic [HANDLE_W-1:0] out_ev_handle_reg, out_ev_handle_next;

    logic                accept;
    logic                rd_en;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_entry;
    entry_t              rd_entry;
    logic [ENTRY_W-1:0]  rd_data;
    logic [CAP_W-1:0]    cap_low;
    logic                has_room;
    logic                cmp_last;
    logic                out_free;

    lkc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    // Effective capacity: zero reads as one, and the fill count never passes
    // the memory depth.
    assign cap_low  = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign has_room = (CMP_W'(fill_reg) < CMP_W'(cap_low)) &&
                      (CMP_W'(fill_reg) < CMP_W'(MAX_ENTRIES));

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign rd_en    = (state_reg == ST_SCAN) && (issue_reg < fill_reg);
    assign cmp_last = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == fill_reg);

    // The entry written back when a request completes: a new entry on an add,
    // or the hit entry with a refreshed stamp on a lookup.
    assign wr_entry.code      = code_reg;
    assign wr_entry.font_size = fsize_reg;
    assign wr_entry.handle    = (cmd_reg == CMD_LOOKUP) ? found_reg : handle_reg;
    assign wr_entry.stamp     = now_reg;
    assign wr_addr            = slot_reg;
    assign wr_en = (state_reg == ST_FINISH) && out_free && !bad_reg &&
                   ((cmd_reg == CMD_ADD) || hit_reg);

    always_comb
    begin
        state_next         = state_reg;
        fill_next          = fill_reg;
        bad_next           = bad_reg;
        append_next        = append_reg;
        hit_next           = hit_reg;
        slot_next          = slot_reg;
        issue_next         = issue_reg;
        best_stamp_next    = best_stamp_reg;
        best_idx_next      = best_idx_reg;
        best_handle_next   = best_handle_reg;
        found_next         = found_reg;
        out_valid_next     = out_valid_reg && !rsp.ready;
        out_status_next    = out_status_reg;
        out_found_next     = out_found_reg;
        out_evicted_next   = out_evicted_reg;
        out_ev_handle_next = out_ev_handle_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bad_next        = 1'b0;
                    append_next     = 1'b0;
                    hit_next        = 1'b0;
                    issue_next      = '0;
                    best_stamp_next = STAMP_NEWEST;
                    best_idx_next   = '0;
                    found_next      = '0;
                    slot_next       = fill_reg[IDX_W-1:0];
                    if (req.command == CMD_ADD)
                    begin
                        if (req.payload_handle == '0)
                        begin
                            // A null handle is refused and leaves no trace.
                            bad_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else if (has_room)
                        begin
                            append_next = 1'b1;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        if ((rd_entry.code == code_reg) &&
                            (rd_entry.font_size == fsize_reg))
                        begin
                            hit_next   = 1'b1;
                            found_next = rd_entry.handle;
                            slot_next  = cmp_idx_reg;
                            state_next = ST_FINISH;
                        end
                        else if (cmp_last)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        // Strict compare keeps the lowest index on ties; entry
                        // zero is always taken first so that a cache full of
                        // newest stamps replaces entry zero.
                        if ((rd_entry.stamp < best_stamp_reg) || (cmp_idx_reg == '0))
                        begin
                            best_stamp_next  = rd_entry.stamp;
                            best_idx_next    = cmp_idx_reg;
                            best_handle_next = rd_entry.handle;
                        end
                        if (cmp_last)
                        begin
                            slot_next  = best_idx_next;
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_found_next     = '0;
                    out_evicted_next   = 1'b0;
                    out_ev_handle_next = '0;
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (bad_reg)
                        begin
                            out_status_next = STATUS_BAD_PARAM;
                        end
                        else
                        begin
                            out_status_next = STATUS_OK;
                            if (append_reg)
                            begin
                                fill_next = fill_reg + CNT_W'(1);
                            end
                            else
                            begin
                                out_evicted_next   = 1'b1;
                                out_ev_handle_next = best_handle_reg;
                            end
                        end
                    end
                    else if (hit_reg)
                    begin
                        out_status_next = STATUS_OK;
                        out_found_next  = found_reg;
                    end
                    else
                    begin
                        out_status_next = STATUS_NOT_FOUND;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAPACITY_RESET;
            fill_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cmp_valid_reg <= rd_en;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.command;
            code_reg   <= req.char_code;
            fsize_reg  <= req.font_size;
            handle_reg <= req.payload_handle;
            now_reg    <= req.now_ms;
        end
        if (rd_en)
        begin
            cmp_idx_reg <= issue_reg[IDX_W-1:0];
        end
        bad_reg           <= bad_next;
        append_reg        <= append_next;
        hit_reg           <= hit_next;
        slot_reg          <= slot_next;
        issue_reg         <= issue_next;
        best_stamp_reg    <= best_stamp_next;
        best_idx_reg      <= best_idx_next;
        best_handle_reg   <= best_handle_next;
        found_reg         <= found_next;
        out_status_reg    <= out_status_next;
        out_found_reg     <= out_found_next;
        out_evicted_reg   <= out_evicted_next;
        out_ev_handle_reg <= out_ev_handle_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_handle   = out_found_reg;
    assign rsp.evicted        = out_evicted_reg;
    assign rsp.evicted_handle = out_ev_handle_reg;

endmodule

### rtl/lkc_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM with a registered read port.
module lkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### tb/lru_keyed_cache_test.sv
`timescale 1ns / 1ps

// Testbench for the glyph cache. Every accepted request beat is run through a
// behavioral copy of the cache kept in this module, and the response it should
// produce is queued. A checker process pops one expectation per accepted
// response beat and compares it field by field. Both channels idle at random,
// and the capacity register is rewritten between phases only after every
// outstanding response has come back.
module lru_keyed_cache_test;
    import lkc_pkg::*;

    localparam int DEPTH = DEFAULT_MAX_ENTRIES;

    // The limit is far longer than a full scan plus the longest sender gap and the
    // longest receiver stall, so a quiet stretch that reaches it means a hang.
    localparam int HANG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 200;
    localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(1114111);

    // One request beat, in the order the fields appear on the channel.
    typedef struct packed {
        logic                command;
        logic [CODE_W-1:0]   char_code;
        logic [FSIZE_W-1:0]  font_size;
        logic [HANDLE_W-1:0] payload_handle;
        logic [STAMP_W-1:0]  now_ms;
    } request_t;

    // One response beat.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] found_handle;
        logic                evicted;
        logic [HANDLE_W-1:0] evicted_handle;
    } response_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [FSIZE_W-1:0] font_size;
    } glyph_key_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    lkc_req_if req();
    lkc_rsp_if rsp();

    lru_keyed_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    // Behavioral copy of the cache: the entry array, how many entries are
    // filled, and the capacity register as last written.
    entry_t           glyph_entries [DEPTH];
    int unsigned      glyph_fill;
    logic [CAP_W-1:0] glyph_capacity;

    // Responses still owed by the cache, oldest first.
    response_t pending_responses [$];

    // Keys that the random traffic draws from, so that lookups hit often.
    glyph_key_t key_pool [$];

    logic [STAMP_W-1:0] render_clock;
    int unsigned        error_count = 0;
    int unsigned        quiet_cycles = 0;

    // While set, neither the sender nor the receiver inserts idle cycles.
    bit steady_flow = 1'b0;

    task automatic report_error(string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Most gaps are zero or short; a few are long enough to cover a whole scan.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Applies one accepted request to the behavioral cache and returns the
    // response beat that the hardware owes for it.
    function automatic response_t apply_glyph_access(request_t r);
        response_t   res;
        int unsigned limit;
        int unsigned slot;
        logic [STAMP_W-1:0] oldest;
        res = '0;
        if (r.command == CMD_ADD) begin
            if (r.payload_handle == '0) begin
                // A null handle is refused and leaves the cache untouched.
                res.status = STATUS_BAD_PARAM;
            end
            else begin
                // Zero acts as one, and anything above the array size saturates.
                if (glyph_capacity == '0)
                    limit = 1;
                else if (glyph_capacity > DEPTH)
                    limit = DEPTH;
                else
                    limit = glyph_capacity;
                if (glyph_fill < limit) begin
                    slot = glyph_fill;
                    glyph_fill++;
                end
                else begin
                    // The strict compare keeps the lowest index on ties, and a
                    // stamp of zero cannot be beaten, so the search stops there.
                    // When every stamp is all ones, entry 0 is replaced.
                    slot = 0;
                    oldest = STAMP_NEWEST;
                    for (int i = 0; i < glyph_fill; i++) begin
                        if (glyph_entries[i].stamp < oldest) begin
                            oldest = glyph_entries[i].stamp;
                            slot = i;
                            if (oldest == '0)
                                break;
                        end
                    end
                    res.evicted = 1'b1;
                    res.evicted_handle = glyph_entries[slot].handle;
                end
                glyph_entries[slot] = '{r.char_code, r.font_size, r.payload_handle, r.now_ms};
            end
        end
        else begin
            res.status = STATUS_NOT_FOUND;
            for (int i = 0; i < glyph_fill; i++) begin
                if (glyph_entries[i].code == r.char_code &&
                    glyph_entries[i].font_size == r.font_size) begin
                    res.found_handle = glyph_entries[i].handle;
                    res.status = STATUS_OK;
                    glyph_entries[i].stamp = r.now_ms;
                    break;
                end
            end
        end
        return res;
    endfunction

    function automatic request_t make_request(logic cmd, int unsigned code,
                                              int unsigned fsize,
                                              logic [HANDLE_W-1:0] handle,
                                              logic [STAMP_W-1:0] now);
        request_t r;
        r.command = cmd;
        r.char_code = CODE_W'(code);
        r.font_size = FSIZE_W'(fsize);
        r.payload_handle = handle;
        r.now_ms = now;
        return r;
    endfunction

    // Render time mostly creeps forward, often without moving at all so that
    // ties in age are common. Now and then it jumps, or sits at either end of
    // its range.
    function automatic logic [STAMP_W-1:0] next_render_time();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            render_clock = render_clock + $urandom_range(0, 3);
        else if (roll < 90)
            render_clock = render_clock + $urandom_range(4, 1000);
        else if (roll < 95)
            render_clock = $urandom();
        else if (roll < 98)
            return '0;
        else
            return STAMP_NEWEST;
        return render_clock;
    endfunction

    // Most glyphs use common text sizes; the rest use any size at all.
    function automatic glyph_key_t fresh_key();
        glyph_key_t k;
        k.code = CODE_W'($urandom_range(0, 1114111));
        if ($urandom_range(0, 99) < 70)
            k.font_size = FSIZE_W'($urandom_range(8, 72));
        else
            k.font_size = FSIZE_W'($urandom_range(0, 65535));
        return k;
    endfunction

    // Drives one request beat after a random gap and returns at the edge that
    // accepted it, with valid still high so that a back-to-back beat can follow
    // without valid dropping.
    task automatic send_request(request_t r);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.command        <= r.command;
        req.char_code      <= r.char_code;
        req.font_size      <= r.font_size;
        req.payload_handle <= r.payload_handle;
        req.now_ms         <= r.now_ms;
        do
            @(posedge clk);
        while (!req.ready);
        pending_responses.push_back(apply_glyph_access(r));
    endtask

    // Stops sending and waits until the cache has answered every request beat.
    // At least one edge passes, so valid never gets two assignments in one step.
    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    // The capacity register is written only with the cache idle. Since every
    // request produces exactly one response, an empty queue means idle.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        glyph_capacity = value;
    endtask

    // Random mix of adds and lookups over a pool of keys. Lookups carry junk in
    // the handle field, and about one add in twenty has a null handle.
    task automatic run_random_traffic(int unsigned count, int unsigned pool_size);
        request_t   r;
        glyph_key_t k;
        key_pool.delete();
        repeat (pool_size) key_pool.push_back(fresh_key());
        repeat (count)
        begin
            r.command = ($urandom_range(0, 99) < 55) ? CMD_LOOKUP : CMD_ADD;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                k = fresh_key();
            r.char_code = k.code;
            r.font_size = k.font_size;
            if (r.command == CMD_ADD && $urandom_range(0, 99) < 5)
                r.payload_handle = '0;
            else
                r.payload_handle = $urandom();
            r.now_ms = next_render_time();
            send_request(r);
        end
    endtask

    // A lookup on an empty cache misses, a null add is refused, and the handle
    // field of a lookup is ignored.
    task automatic test_empty_cache_and_null_handle();
        send_request(make_request(CMD_LOOKUP, 'h41, 12, '0, 10));
        send_request(make_request(CMD_ADD, 'h41, 12, '0, 11));
        send_request(make_request(CMD_LOOKUP, 'h41, 12, 32'hdead_beef, 12));
    endtask

    // A capacity of zero behaves as one: the second add already evicts.
    task automatic test_capacity_zero_acts_as_one();
        write_capacity('0);
        send_request(make_request(CMD_ADD, 'h41, 12, 32'h1000_0001, 20));
        send_request(make_request(CMD_ADD, 'h42, 12, 32'h1000_0002, 21));
        send_request(make_request(CMD_LOOKUP, 'h41, 12, '0, 22));
        send_request(make_request(CMD_LOOKUP, 'h42, 12, '0, 22));
    endtask

    // With room for four entries, walk the replacement rules: equal ages go to
    // the lowest index, a zero stamp wins at once, all-ones stamps leave entry
    // 0 as the victim, and a duplicate key is stored without any check.
    task automatic test_eviction_order();
        write_capacity(CAP_W'(4));
        send_request(make_request(CMD_ADD, 'h43, 12, 32'h1000_0003, 30));
        send_request(make_request(CMD_ADD, 'h44, 12, 32'h1000_0004, 30));
        send_request(make_request(CMD_ADD, 'h45, 12, 32'h1000_0005, 30));
        // Refresh all four to the same time, then add: index 0 must go.
        send_request(make_request(CMD_LOOKUP, 'h42, 12, '0, 40));
        send_request(make_request(CMD_LOOKUP, 'h43, 12, '0, 40));
        send_request(make_request(CMD_LOOKUP, 'h44, 12, '0, 40));
        send_request(make_request(CMD_LOOKUP, 'h45, 12, '0, 40));
        send_request(make_request(CMD_ADD, 'h46, 12, 32'h1000_0006, 41));
        // Two entries touched at time zero: the first of them is replaced.
        send_request(make_request(CMD_LOOKUP, 'h44, 12, '0, 0));
        send_request(make_request(CMD_LOOKUP, 'h45, 12, '0, 0));
        send_request(make_request(CMD_ADD, 'h47, 12, 32'h1000_0007, 42));
        // Every entry at the newest possible stamp.
        send_request(make_request(CMD_LOOKUP, 'h46, 12, '0, STAMP_NEWEST));
        send_request(make_request(CMD_LOOKUP, 'h43, 12, '0, STAMP_NEWEST));
        send_request(make_request(CMD_LOOKUP, 'h47, 12, '0, STAMP_NEWEST));
        send_request(make_request(CMD_LOOKUP, 'h45, 12, '0, STAMP_NEWEST));
        send_request(make_request(CMD_ADD, 'h48, 12, 32'h1000_0008, 43));
        // Second copy of a key that is still stored; the lookup sees the lower one.
        send_request(make_request(CMD_ADD, 'h43, 12, 32'h2000_0003, 44));
        send_request(make_request(CMD_LOOKUP, 'h43, 12, '0, 45));
    endtask

    // Capacity dropped below the fill count: nothing is dropped, and the age
    // search still covers every filled entry.
    task automatic test_capacity_below_fill();
        write_capacity(CAP_W'(2));
        send_request(make_request(CMD_ADD, 'h49, 12, 32'h1000_0009, 50));
        send_request(make_request(CMD_ADD, 'h4a, 12, 32'h1000_000a, 51));
    endtask

    // Extreme field values, with the register at its top value, which the
    // cache treats as its array size.
    task automatic test_field_extremes();
        write_capacity(CAP_W'(127));
        send_request(make_request(CMD_ADD, 0, 0, 32'hffff_ffff, STAMP_NEWEST));
        send_request(make_request(CMD_ADD, CODE_MAX, 16'hffff, 32'h1, '0));
        send_request(make_request(CMD_LOOKUP, 0, 0, 32'hffff_ffff, 32'h1));
        send_request(make_request(CMD_LOOKUP, CODE_MAX, 16'hffff, '0, STAMP_NEWEST));
        send_request(make_request(CMD_LOOKUP, 0, 16'hffff, '0, 32'h2));
    endtask

    // Moderate capacity: the cache fills up to 16 entries and then evicts.
    task automatic test_random_partial_capacity();
        write_capacity(CAP_W'(16));
        run_random_traffic(200, 40);
    endtask

    // Full-size cache with a stretch in the middle where neither side idles.
    task automatic test_random_full_cache();
        write_capacity(CAP_W'(64));
        run_random_traffic(100, 96);
        steady_flow = 1'b1;
        run_random_traffic(100, 96);
        steady_flow = 1'b0;
        run_random_traffic(100, 96);
    endtask

    // Saturating capacity, with the sender holding off once until all
    // responses are back, then a capacity of one on a full cache.
    task automatic test_random_with_drain();
        write_capacity(CAP_W'($urandom_range(65, 127)));
        run_random_traffic(100, 80);
        wait_drained();
        run_random_traffic(100, 80);
        write_capacity(CAP_W'(1));
        run_random_traffic(50, 80);
    endtask

    // Receiver: holds ready off for a random stretch after each beat, and now
    // and then while nothing is offered, so stalls land on every phase of a
    // request. Each accepted beat is checked against the oldest expectation.
    initial
    begin : response_checker
        response_t   want;
        int unsigned stall;
        bit          took;
        rsp.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            took = rsp.valid && rsp.ready;
            if (took) begin
                if (pending_responses.size() == 0) begin
                    report_error("response beat with no request outstanding");
                end
                else begin
                    want = pending_responses.pop_front();
                    if (rsp.status !== want.status)
                        report_error($sformatf("status %0d, expected %0d",
                                               rsp.status, want.status));
                    if (rsp.found_handle !== want.found_handle)
                        report_error($sformatf("found_handle %h, expected %h",
                                               rsp.found_handle, want.found_handle));
                    if (rsp.evicted !== want.evicted)
                        report_error($sformatf("evicted %b, expected %b",
                                               rsp.evicted, want.evicted));
                    if (rsp.evicted_handle !== want.evicted_handle)
                        report_error($sformatf("evicted_handle %h, expected %h",
                                               rsp.evicted_handle, want.evicted_handle));
                end
                stall = pick_gap();
            end
            else if (!rsp.valid && stall == 0 && $urandom_range(0, 99) < 5) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Hang detector: any beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == HANG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        req.valid          = 1'b0;
        req.command        = CMD_ADD;
        req.char_code      = '0;
        req.font_size      = '0;
        req.payload_handle = '0;
        req.now_ms         = '0;
        glyph_fill     = 0;
        glyph_capacity = CAPACITY_RESET;
        render_clock   = 32'd1000;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_cache_and_null_handle();
        test_capacity_zero_acts_as_one();
        test_eviction_order();
        test_capacity_below_fill();
        test_field_extremes();
        test_random_partial_capacity();
        test_random_full_cache();
        test_random_with_drain();

        // Let every response come back, then watch a while longer for
        // stray beats before deciding.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
rtl/lkc_pkg.sv
rtl/lkc_if.sv
rtl/lkc_ram.sv
rtl/lru_keyed_cache.sv
tb/lru_keyed_cache_test.sv
